@@ design/esc_pkg.sv @@
// Package: shared widths, codes and payload types of the elevator scan controller.
package esc_pkg;

  localparam int unsigned FloorW = 6;
  localparam int unsigned KindW  = 2;
  localparam int unsigned MotionW = 2;
  localparam int unsigned DwellW = 8;

  localparam logic [DwellW-1:0] DwellReset = 8'd3;

  // Request operation codes.
  localparam logic OpTick    = 1'b0;
  localparam logic OpRequest = 1'b1;

  // Call kinds of a floor request.
  localparam logic [KindW-1:0] CallUp   = 2'd0;
  localparam logic [KindW-1:0] CallStop = 2'd1;
  localparam logic [KindW-1:0] CallDown = 2'd2;

  // Motion codes as reported on the result channel.
  localparam logic [MotionW-1:0] MotionIdle = 2'd0;
  localparam logic [MotionW-1:0] MotionUp   = 2'd1;
  localparam logic [MotionW-1:0] MotionDown = 2'd2;

  // Sweep direction codes.
  localparam logic DirUp   = 1'b0;
  localparam logic DirDown = 1'b1;

  // Car state machine, one-hot.
  typedef enum logic [2:0] {
    CarIdle = 3'b001,
    CarUp   = 3'b010,
    CarDown = 3'b100
  } car_state_e;

endpackage

@@ design/esc_req_if.sv @@
// Interface: request channel carrying ticks and floor requests.
interface esc_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [esc_pkg::FloorW-1:0] floor_number;
  logic [esc_pkg::KindW-1:0]  call_kind;

  modport source (output valid, output operation, output floor_number, output call_kind,
                  input ready);
  modport sink   (input valid, input operation, input floor_number, input call_kind,
                  output ready);
endinterface

@@ design/esc_rsp_if.sv @@
// Interface: result channel reporting the car status after each request.
interface esc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [esc_pkg::FloorW-1:0]  car_floor;
  logic [esc_pkg::MotionW-1:0] motion_state;
  logic                        heading;
  logic                        pending;

  modport source (output valid, output car_floor, output motion_state, output heading,
                  output pending, input ready);
  modport sink   (input valid, input car_floor, input motion_state, input heading,
                  input pending, output ready);
endinterface

@@ design/elevator_scan_controller_unit.sv @@
// Top level: SCAN-style single-car elevator controller with a registered result stage.
//
//   Channel   Direction  Handshake        Carries
//   req_i     in         valid/ready      operation, floor_number, call_kind
//   rsp_o     out        valid/ready      car_floor, motion_state, heading, pending
//   cfg       in         cfg_we_i only    dwell_ticks (8 bits)
//
// For every request, the car state is updated at the edge that accepts it,
// and the status after that update is loaded into the result register at the same edge.
// The only loop is the state update itself, so one request is accepted per cycle unless a held result stalls it.
// The result register frees up at the edge where its contents are taken, so a new
// request is accepted while the previous result is being handed off; only a held
// result with rsp_o.ready low stalls the request side.
// Reset clears all request flags, puts the car idle at the ground floor heading up,
// and loads dwell_ticks with 3.
module elevator_scan_controller_unit #(
  parameter int unsigned FLOORS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  esc_req_if.sink                    req_i,
  esc_rsp_if.source                  rsp_o,
  input  logic                       cfg_we_i,
  input  logic [esc_pkg::DwellW-1:0] cfg_wdata_i
);
  import esc_pkg::*;

  // Index width into the per-floor flag vectors.
  localparam int unsigned IdxW = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  // Wide enough to hold FLOORS itself for the range check.
  localparam int unsigned RangeW = FloorW + 1;
  localparam logic [RangeW-1:0] FloorsTop = RangeW'(FLOORS);

  // Architectural state.
  logic [FLOORS-1:0] up_calls_q, up_calls_d;
  logic [FLOORS-1:0] stop_calls_q, stop_calls_d;
  logic [FLOORS-1:0] down_calls_q, down_calls_d;
  logic [FloorW-1:0] floor_q, floor_d;
  car_state_e        car_q, car_d;
  logic              dir_q, dir_d;
  logic [DwellW-1:0] dwell_left_q, dwell_left_d;
  logic [DwellW-1:0] dwell_ticks_q;

  // Result register.
  logic               rsp_valid_q;
  logic [FloorW-1:0]  rsp_floor_q;
  logic [MotionW-1:0] rsp_motion_q;
  logic               rsp_heading_q;
  logic               rsp_pending_q;
  logic [MotionW-1:0] motion_d;

  logic req_fire;

  // Decode of the current floor and of requests above and below it.
  logic [IdxW-1:0]   here_idx;
  logic [FLOORS-1:0] any_calls;
  logic [FLOORS-1:0] above_mask;
  logic [FLOORS-1:0] below_mask;
  logic [FLOORS-1:0] here_mask;
  logic              req_above;
  logic              req_below;
  logic              serve_up;
  logic              serve_down;

  // Decode of a floor request.
  logic [RangeW-1:0] req_floor_ext;
  logic              req_in_range;
  logic [FloorW-1:0] req_floor_idx;
  logic [FLOORS-1:0] req_bit;

  // A new request is taken whenever the result register is empty or being emptied.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  assign here_idx  = floor_q[IdxW-1:0];
  assign any_calls = up_calls_q | stop_calls_q | down_calls_q;

  always_comb begin
    for (int i = 0; i < FLOORS; i++) begin
      above_mask[i] = FloorW'(i) > floor_q;
      below_mask[i] = FloorW'(i) < floor_q;
      here_mask[i]  = FloorW'(i) == floor_q;
    end
  end

  assign req_above  = |(any_calls & above_mask);
  assign req_below  = |(any_calls & below_mask);
  assign serve_up   = up_calls_q[here_idx] || stop_calls_q[here_idx];
  assign serve_down = down_calls_q[here_idx] || stop_calls_q[here_idx];

  // Floor numbers on the request are one-based; zero and anything above FLOORS drop.
  assign req_floor_ext = {1'b0, req_i.floor_number};
  assign req_in_range  = (req_i.floor_number != '0) && (req_floor_ext <= FloorsTop);
  assign req_floor_idx = req_i.floor_number - 1'b1;

  always_comb begin
    for (int i = 0; i < FLOORS; i++) begin
      req_bit[i] = req_in_range && (FloorW'(i) == req_floor_idx);
    end
  end

  // Next-state logic for one accepted request.
  always_comb begin
    up_calls_d   = up_calls_q;
    stop_calls_d = stop_calls_q;
    down_calls_d = down_calls_q;
    floor_d      = floor_q;
    car_d        = car_q;
    dir_d        = dir_q;
    dwell_left_d = dwell_left_q;

    if (req_i.operation == OpRequest) begin
      // An unknown call kind sets nothing.
      case (req_i.call_kind)
        CallUp:   up_calls_d   = up_calls_q | req_bit;
        CallStop: stop_calls_d = stop_calls_q | req_bit;
        CallDown: down_calls_d = down_calls_q | req_bit;
        default:  ;
      endcase
    end else begin
      case (car_q)
        CarUp: begin
          if (serve_up) begin
            car_d        = CarIdle;
            dwell_left_d = dwell_ticks_q;
          end else if (req_above) begin
            floor_d = floor_q + 1'b1;
          end else begin
            car_d = CarDown;
            dir_d = DirDown;
          end
        end
        CarDown: begin
          if (serve_down) begin
            car_d        = CarIdle;
            dwell_left_d = dwell_ticks_q;
          end else if (req_below) begin
            floor_d = floor_q - 1'b1;
          end else begin
            car_d = CarUp;
            dir_d = DirUp;
          end
        end
        default: begin
          // Dwelling: once the count has run out, clear this floor and pick a way to go.
          // Clearing the current floor does not affect the above/below checks.
          if (dwell_left_q == '0) begin
            up_calls_d   = up_calls_q & ~here_mask;
            stop_calls_d = stop_calls_q & ~here_mask;
            down_calls_d = down_calls_q & ~here_mask;
            if (dir_q == DirUp) begin
              car_d = req_above ? CarUp : CarDown;
            end else begin
              car_d = req_below ? CarDown : CarUp;
            end
          end else begin
            dwell_left_d = dwell_left_q - 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    case (car_d)
      CarUp:   motion_d = MotionUp;
      CarDown: motion_d = MotionDown;
      default: motion_d = MotionIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_calls_q    <= '0;
      stop_calls_q  <= '0;
      down_calls_q  <= '0;
      floor_q       <= '0;
      car_q         <= CarIdle;
      dir_q         <= DirUp;
      dwell_left_q  <= '0;
      dwell_ticks_q <= DwellReset;
      rsp_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dwell_ticks_q <= cfg_wdata_i;
      end
      if (req_fire) begin
        up_calls_q   <= up_calls_d;
        stop_calls_q <= stop_calls_d;
        down_calls_q <= down_calls_d;
        floor_q      <= floor_d;
        car_q        <= car_d;
        dir_q        <= dir_d;
        dwell_left_q <= dwell_left_d;
        rsp_valid_q  <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is only looked at while valid is high.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_floor_q   <= floor_d;
      rsp_motion_q  <= motion_d;
      rsp_heading_q <= dir_d;
      rsp_pending_q <= |(up_calls_d | stop_calls_d | down_calls_d);
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.car_floor    = rsp_floor_q;
  assign rsp_o.motion_state = rsp_motion_q;
  assign rsp_o.heading      = rsp_heading_q;
  assign rsp_o.pending      = rsp_pending_q;

endmodule
